// ===== sv/irpde_pkg.sv =====
// ----------------------------------------------------------------------------
// irpde_pkg
// Shared types and constants for the IR pulse-distance frame encoder.
// ----------------------------------------------------------------------------
package irpde_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 2;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 12;
    localparam int DUR_W   = 16;
    localparam int FMT_W   = 2;
    localparam int CFG_W   = 12;
    localparam int SEG_W   = 5;

    localparam logic [FMT_W-1:0] FMT_NONE = 2'd0;
    localparam logic [FMT_W-1:0] FMT_NEC  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_AEHA = 2'd2;

    localparam logic REG_FRAME_FORMAT = 1'b0;
    localparam logic REG_UNIT_TIME    = 1'b1;

    localparam logic [FMT_W-1:0]  FRAME_FORMAT_RESET = FMT_NEC;
    localparam logic [UNIT_W-1:0] UNIT_TIME_RESET    = 12'd562;

    // Segment positions within one item
    localparam logic [SEG_W-1:0] SEG_LEAD_MARK  = 5'd0;
    localparam logic [SEG_W-1:0] SEG_LEAD_SPACE = 5'd1;
    localparam logic [SEG_W-1:0] SEG_BIT_FIRST  = 5'd2;
    localparam logic [SEG_W-1:0] SEG_BIT_LAST   = 5'd17;
    localparam logic [SEG_W-1:0] SEG_STOP       = 5'd18;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              present;
        logic              first;
        logic              last;
        logic              aeha;
        logic [UNIT_W-1:0] unit;
    } job_t;

endpackage

// ===== sv/ir_pulse_distance_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_encoder
// Turns IR frame bytes into timed mark and space segments (NEC / AEHA).
//
// Channel   Direction  Handshake        Word
// config    in         cfg_we           cfg_index, cfg_data
// items     in         push / full      data_byte, byte_present, frame_first,
//                                       frame_last
// segments  out        empty / pop      mark_level, duration_us, run_last
//
// One segment leaves per cycle while the output register is free or popped;
// a full byte with leader and stop is 19 segments, a bare byte 16. Words are
// queued while earlier ones are sequenced, so the input stalls only when the
// job queue is full. Words that produce no segment are dropped on entry. Reset
// clears the queue and the output register and loads the register reset values.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_encoder
    import irpde_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              byte_present,
    input  logic              frame_first,
    input  logic              frame_last,
    output logic              empty,
    input  logic              pop,
    output logic              mark_level,
    output logic [DUR_W-1:0]  duration_us,
    output logic              run_last
);

    logic q_wr_en;
    job_t q_wr_data;
    logic q_rd_en;
    job_t q_rd_data;
    logic q_empty;

    irpde_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .q_full       (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .q_wr_en      (q_wr_en),
        .q_wr_data    (q_wr_data)
    );

    irpde_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_wr_en),
        .wr_data    (q_wr_data),
        .rd_en      (q_rd_en),
        .rd_data    (q_rd_data),
        .fifo_full  (full),
        .fifo_empty (q_empty)
    );

    irpde_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_rd_data),
        .q_empty     (q_empty),
        .q_rd_en     (q_rd_en),
        .pop         (pop),
        .empty       (empty),
        .mark_level  (mark_level),
        .duration_us (duration_us),
        .run_last    (run_last)
    );

endmodule

// ===== sv/irpde_fifo.sv =====
// ----------------------------------------------------------------------------
// irpde_fifo
// Short job queue between the classifier and the segment sequencer.
// ----------------------------------------------------------------------------
module irpde_fifo
    import irpde_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    input  logic rd_en,
    output job_t rd_data,
    output logic fifo_full,
    output logic fifo_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign fifo_full  = (count_reg == CNT_W'(DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/irpde_front.sv =====
// ----------------------------------------------------------------------------
// irpde_front
// Configuration registers and word classifier: drops words that produce no
// segments and queues the rest with the format and unit time they need.
// ----------------------------------------------------------------------------
module irpde_front
    import irpde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              push,
    input  logic              q_full,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              byte_present,
    input  logic              frame_first,
    input  logic              frame_last,
    output logic              q_wr_en,
    output job_t              q_wr_data
);

    logic [FMT_W-1:0]  frame_format_reg;
    logic [UNIT_W-1:0] unit_time_reg;
    logic              fmt_valid;
    logic              has_segments;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_format_reg <= FRAME_FORMAT_RESET;
            unit_time_reg    <= UNIT_TIME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_FORMAT: frame_format_reg <= cfg_data[FMT_W-1:0];
                REG_UNIT_TIME:    unit_time_reg    <= cfg_data[UNIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        fmt_valid    = (frame_format_reg == FMT_NEC) || (frame_format_reg == FMT_AEHA);
        has_segments = frame_first || byte_present || frame_last;
        q_wr_en      = push && !q_full && fmt_valid && has_segments;

        q_wr_data.data_byte = data_byte;
        q_wr_data.present   = byte_present;
        q_wr_data.first     = frame_first;
        q_wr_data.last      = frame_last;
        q_wr_data.aeha      = (frame_format_reg == FMT_AEHA);
        q_wr_data.unit      = unit_time_reg;
    end

endmodule

// ===== sv/irpde_back.sv =====
// ----------------------------------------------------------------------------
// irpde_back
// Segment sequencer: walks the head job one segment per cycle into the output
// register while it is free or popped and releases the job on its final segment.
// ----------------------------------------------------------------------------
module irpde_back
    import irpde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  job_t             head,
    input  logic             q_empty,
    output logic             q_rd_en,
    input  logic             pop,
    output logic             empty,
    output logic             mark_level,
    output logic [DUR_W-1:0] duration_us,
    output logic             run_last
);

    logic             busy_reg;
    logic             busy_next;
    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             mark_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             last_reg;

    logic [SEG_W-1:0] start_seg;
    logic [SEG_W-1:0] cur_seg;
    logic [SEG_W-1:0] after_seg;
    logic [SEG_W-1:0] bit_pos;
    logic             seg_done;
    logic             emit;
    logic             seg_mark;
    logic [DUR_W-1:0] seg_dur;
    logic [DUR_W-1:0] t1;
    logic [DUR_W-1:0] t3;

    assign empty       = !out_valid_reg;
    assign mark_level  = mark_reg;
    assign duration_us = dur_reg;
    assign run_last    = last_reg;

    always_comb
    begin
        start_seg = head.first ? SEG_LEAD_MARK : (head.present ? SEG_BIT_FIRST : SEG_STOP);
        cur_seg   = busy_reg ? seg_reg : start_seg;
        after_seg = cur_seg + 1'b1;
        seg_done  = 1'b0;
        unique case (cur_seg)
            SEG_LEAD_SPACE:
            begin
                after_seg = head.present ? SEG_BIT_FIRST : SEG_STOP;
                seg_done  = !head.present && !head.last;
            end
            SEG_BIT_LAST:
            begin
                after_seg = SEG_STOP;
                seg_done  = !head.last;
            end
            SEG_STOP:
            begin
                seg_done = 1'b1;
            end
            default: ;
        endcase

        t1      = DUR_W'(head.unit);
        t3      = t1 + (t1 << 1);
        bit_pos = cur_seg - SEG_BIT_FIRST;
        seg_mark = 1'b1;
        seg_dur  = t1;
        if (cur_seg == SEG_LEAD_MARK)
        begin
            seg_dur = head.aeha ? (t1 << 3) : (t1 << 4);
        end
        else if (cur_seg == SEG_LEAD_SPACE)
        begin
            seg_mark = 1'b0;
            seg_dur  = head.aeha ? (t1 << 2) : (t1 << 3);
        end
        else if (cur_seg != SEG_STOP && cur_seg[0])
        begin
            seg_mark = 1'b0;
            seg_dur  = head.data_byte[bit_pos[3:1]] ? t3 : t1;
        end

        emit    = !q_empty && (!out_valid_reg || pop);
        q_rd_en = emit && seg_done;

        busy_next = busy_reg;
        seg_next  = seg_reg;
        if (emit)
        begin
            busy_next = !seg_done;
            seg_next  = after_seg;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_reg       <= SEG_LEAD_MARK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            mark_reg <= seg_mark;
            dur_reg  <= seg_dur;
            last_reg <= seg_done;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !q_empty)
        else $error("sequencer busy without a queued job");

    a_busy_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (seg_reg >= SEG_LEAD_SPACE) && (seg_reg <= SEG_STOP))
        else $error("sequencer position out of range");

    a_release_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |=> out_valid_reg && run_last && !busy_reg)
        else $error("job released without a final segment");

    a_mid_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !seg_done |=> busy_reg && !run_last)
        else $error("job dropped before its final segment");
`endif

endmodule

// ===== tb/tb_ir_pulse_distance_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_frame_encoder
// Self-checking bench for the IR pulse-distance frame encoder. The bench
// drives frame words through the push/full side and pops segments under
// random stalls. A scoreboard predicts the leader, bit and stop segments from
// its own copy of the format and unit-time registers, and compares each
// popped segment with the oldest prediction. Directed words cover the field
// extremes and each format. Random phases follow, each with its own register
// setting. Most random words form frames, some without a stop, the rest noise.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_encoder;
    import irpde_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic             mark;
        logic [DUR_W-1:0] dur;
        logic             fin;
    } segment_t;

    class segment_scoreboard;
        segment_t          pending_segments[$];
        logic [FMT_W-1:0]  fmt;
        logic [UNIT_W-1:0] unit;
        int                errors;

        function new();
            fmt = FRAME_FORMAT_RESET;
            unit = UNIT_TIME_RESET;
            errors = 0;
        endfunction

        function void write_register(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_FRAME_FORMAT)
            begin
                fmt = value[FMT_W-1:0];
            end
            else
            begin
                unit = value[UNIT_W-1:0];
            end
        endfunction

        function void add_segment(logic mark, logic [DUR_W-1:0] dur);
            segment_t s;
            s.mark = mark;
            s.dur = dur;
            s.fin = 1'b0;
            pending_segments.push_back(s);
        endfunction

        function int note_word(logic [BYTE_W-1:0] data, logic present,
                               logic first, logic last);
            logic [DUR_W-1:0] t;
            logic [DUR_W-1:0] lead_mark;
            logic [DUR_W-1:0] lead_space;
            int               n;
            n = pending_segments.size();
            t = DUR_W'(unit);
            if (fmt == FMT_NEC)
            begin
                lead_mark = t << 4;
                lead_space = t << 3;
            end
            else if (fmt == FMT_AEHA)
            begin
                lead_mark = t << 3;
                lead_space = t << 2;
            end
            else
            begin
                return 0;
            end
            if (first)
            begin
                add_segment(1'b1, lead_mark);
                add_segment(1'b0, lead_space);
            end
            if (present)
            begin
                for (int b = 0; b < BYTE_W; b++)
                begin
                    add_segment(1'b1, t);
                    add_segment(1'b0, data[b] ? DUR_W'(t * 3) : t);
                end
            end
            if (last)
            begin
                add_segment(1'b1, t);
            end
            if (pending_segments.size() > n)
            begin
                pending_segments[pending_segments.size() - 1].fin = 1'b1;
            end
            return pending_segments.size() - n;
        endfunction

        task report(string what, int expected, int actual);
            $display("mismatch: %s expected %0d got %0d", what, expected, actual);
            errors++;
        endtask

        task check_segment(logic mark, logic [DUR_W-1:0] dur, logic fin);
            segment_t s;
            if (pending_segments.size() == 0)
            begin
                report("unexpected segment, pending count", 0, 1);
            end
            else
            begin
                s = pending_segments.pop_front();
                if (mark !== s.mark)
                    report("mark_level", int'(s.mark), int'(mark));
                if (dur !== s.dur)
                    report("duration_us", int'(s.dur), int'(dur));
                if (fin !== s.fin)
                    report("run_last", int'(s.fin), int'(fin));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              push;
    logic              full;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              frame_first;
    logic              frame_last;
    logic              empty;
    logic              pop;
    logic              mark_level;
    logic [DUR_W-1:0]  duration_us;
    logic              run_last;

    segment_scoreboard sb = new();
    int                productive_words = 0;
    int                cycles = 0;
    int                pop_hold = 0;
    bit                idle_on = 1'b1;

    ir_pulse_distance_frame_encoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .empty        (empty),
        .pop          (pop),
        .mark_level   (mark_level),
        .duration_us  (duration_us),
        .run_last     (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_register(cfg_index, cfg_data);
            if (push && !full)
            begin
                if (sb.note_word(data_byte, byte_present, frame_first, frame_last) > 0)
                    productive_words++;
            end
            if (pop && !empty)
                sb.check_segment(mark_level, duration_us, run_last);
        end
    end

    // stall the segment side in random bursts while idle_on is set
    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop = 1'b0;
            pop_hold--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pop = 1'b0;
            pop_hold = $urandom_range(0, 6);
        end
        else
        begin
            pop = 1'b1;
        end
    end

    task send_word(logic [BYTE_W-1:0] data, logic present, logic first, logic last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        data_byte = data;
        byte_present = present;
        frame_first = first;
        frame_last = last;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
    endtask

    task write_reg(logic idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task drain;
        @(negedge clk);
        push = 1'b0;
        while (sb.pending_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task send_frame;
        int  n;
        bit  broken;
        bit  bare_leader;
        n = $urandom_range(1, 5);
        broken = ($urandom_range(0, 7) == 0);
        bare_leader = ($urandom_range(0, 5) == 0);
        if (bare_leader)
            send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            send_word(BYTE_W'($urandom_range(0, 255)), 1'b1, !bare_leader && i == 0,
                      !broken && i == n - 1);
        end
    endtask

    task send_noise;
        send_word(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [CFG_W-1:0] fmt_value;
        logic [CFG_W-1:0] unit_value;
        int               goal;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_FORMAT;
        cfg_data = '0;
        push = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        frame_first = 1'b0;
        frame_last = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: NEC at the default unit time
        send_word(8'hA5, 1'b1, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0, 1'b0);
        send_word(8'h5A, 1'b1, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0, 1'b0);
        send_word(8'h01, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(REG_UNIT_TIME, 12'hFFF);
        send_word(8'hFF, 1'b1, 1'b1, 1'b1);
        drain();
        write_reg(REG_FRAME_FORMAT, CFG_W'(FMT_AEHA));
        send_word(8'h80, 1'b1, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1, 1'b1);
        drain();
        write_reg(REG_UNIT_TIME, 12'd1);
        send_word(8'h3C, 1'b1, 1'b1, 1'b1);
        drain();
        write_reg(REG_UNIT_TIME, 12'd0);
        send_word(8'hC3, 1'b1, 1'b1, 1'b1);
        drain();
        write_reg(REG_FRAME_FORMAT, 12'hFFC);
        send_word(8'hFF, 1'b1, 1'b1, 1'b1);
        drain();
        write_reg(REG_FRAME_FORMAT, 12'h003);
        send_word(8'h55, 1'b1, 1'b1, 1'b1);
        drain();
        write_reg(REG_FRAME_FORMAT, 12'hFFD);
        send_word(8'h96, 1'b1, 1'b1, 1'b1);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 6)
                idle_on = 1'b0;
            if (ph == 2)
                fmt_value = CFG_W'(FMT_NONE);
            else if (ph == 4)
                fmt_value = 12'hFFF;
            else
                fmt_value = $urandom_range(0, 1) ? CFG_W'(FMT_NEC) : CFG_W'(FMT_AEHA);
            if (ph == 1)
                unit_value = 12'hFFF;
            else if (ph == 3)
                unit_value = 12'd1;
            else
                unit_value = CFG_W'($urandom_range(1, 4095));
            write_reg(REG_FRAME_FORMAT, fmt_value);
            write_reg(REG_UNIT_TIME, unit_value);
            if (fmt_value[FMT_W-1:0] == FMT_NEC || fmt_value[FMT_W-1:0] == FMT_AEHA)
            begin
                goal = productive_words + 20;
                while (productive_words < goal)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_noise();
                    else
                        send_frame();
                end
            end
            else
            begin
                repeat (6) send_frame();
                repeat (4) send_noise();
            end
            drain();
        end

        while (sb.pending_segments.size() != 0)
            sb.check_segment(1'bx, 'x, 1'bx);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
